// ----- sv/assert_macros.svh -----
// assertion macros for the rtl files (included by the top level)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check sampled on the rising clock, ignored while reset is held
`define BDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check sampled on the rising clock, also active during reset
`define BDS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/bds_pkg.sv -----
// package: widths, register indexes and block arithmetic for the downsampler
`default_nettype none

package bds_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int PIX_W         = 8;
    localparam int IMG_W_W       = 13;
    localparam int CFG_IDX_W     = 2;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = IMG_W_W'(640);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_MODE  = CFG_IDX_W'(1);

    localparam logic MODE_DOUBLE_ROUND = 1'b0;
    localparam logic MODE_FLOOR_SUM    = 1'b1;

    // 2x2 block average, two rounding flavors
    function automatic logic [PIX_W-1:0] block_value(
        input logic [PIX_W-1:0] tl,
        input logic [PIX_W-1:0] tr,
        input logic [PIX_W-1:0] bl,
        input logic [PIX_W-1:0] br,
        input logic             mode
    );
        logic [PIX_W+1:0] left_sum;
        logic [PIX_W+1:0] right_sum;
        logic [PIX_W+1:0] avg_sum;
        logic [PIX_W+1:0] full_sum;
        left_sum  = {2'b00, tl} + {2'b00, bl} + (PIX_W+2)'(1);
        right_sum = {2'b00, tr} + {2'b00, br} + (PIX_W+2)'(1);
        avg_sum   = {1'b0, left_sum[PIX_W+1:1]} + {1'b0, right_sum[PIX_W+1:1]};
        full_sum  = {2'b00, tl} + {2'b00, tr} + {2'b00, bl} + {2'b00, br};
        if (mode == MODE_FLOOR_SUM) begin
            block_value = full_sum[PIX_W+1:2];
        end else begin
            block_value = avg_sum[PIX_W:1];
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/bds_line_store.sv -----
// line store: single-port synchronous ram holding the upper row of each pair
`default_nettype none

module bds_line_store #(
    parameter int DEPTH = bds_pkg::MAX_WIDTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic                      i_rd_en,
    input  wire logic [AW-1:0]             i_addr,
    input  wire logic [bds_pkg::PIX_W-1:0] i_wdata,
    output logic      [bds_pkg::PIX_W-1:0] o_rd_data
);
    import bds_pkg::*;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // read data registered, old contents on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- sv/box_downsample_2x2.sv -----
// top level: 2x2 box-filter downsampler for an 8-bit grey raster stream
// usage
//   input channel: i_in_valid / o_in_stall carry one pixel per item with a
//   start-of-frame flag; an item is taken at an edge with valid high, stall low
//   output channel: o_out_valid / i_out_stall carry one averaged pixel for each
//   2x2 block plus a flag on the last block of an output row
//   config channel: i_cfg_valid / o_cfg_ready write image_width (index 0) or
//   round_mode (index 1); ready is always high, write only while idle
//   throughput: one item per clock when not stalled, even and odd rows alike;
//   the line store has one port and every item uses it exactly once
//   result path: the block enters the compute stage as its lower-right pixel
//   is taken, with the ram read, then the output register once it is free;
//   even rows are written to the line store; odd rows read the two upper
//   pixels back one column at a time, the left one is kept in a register
//   stall: when the receiver stalls, the output register holds its item and
//   one more result waits in the compute stage; input stalls only when that
//   stage holds a result that cannot move
//   reset: position returns to row 0 column 0, registers take their reset
//   values (width 640, mode 0); the line store is not cleared and needs no
//   clearing pass, an even row always writes before the odd row reads
`default_nettype none
`include "assert_macros.svh"

module box_downsample_2x2 #(
    parameter int MAX_WIDTH = bds_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input pixel channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [bds_pkg::PIX_W-1:0]     i_pixel,
    input  wire logic                          i_start_of_frame,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [bds_pkg::PIX_W-1:0]     o_out_pixel,
    output logic                               o_last_in_row,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bds_pkg::IMG_W_W-1:0]   i_cfg_data
);
    import bds_pkg::*;

    // column index covers the store, length can reach MAX_WIDTH itself
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LEN_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (LEN_W > IMG_W_W) ? LEN_W : IMG_W_W;

    // configuration registers
    logic [IMG_W_W-1:0] r_image_width;
    logic               r_round_mode;

    // position state
    logic [COL_W-1:0]   r_col;
    logic               r_row_odd;
    logic [PIX_W-1:0]   r_held;

    // compute stage: one block waiting for its upper-right pixel from ram
    logic               r_s1_valid;
    logic [PIX_W-1:0]   r_s1_br;
    logic               r_s1_last;
    logic [PIX_W-1:0]   r_tl;

    // output register
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_out_pixel;
    logic               r_out_last;

    logic [CMP_W-1:0]   w_width_ext;
    logic [LEN_W-1:0]   w_len;
    logic [LEN_W-1:0]   w_paired;
    logic [COL_W-1:0]   w_col;
    logic [LEN_W-1:0]   w_col_ext;
    logic [LEN_W-1:0]   w_col_next;
    logic               w_row_odd;
    logic               w_row_end;
    logic               w_accept;
    logic               w_block;
    logic               w_out_free;
    logic               w_s1_adv;
    logic [PIX_W-1:0]   w_rd_data;
    logic               w_mid_row;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= IMAGE_WIDTH_RST;
            r_round_mode  <= MODE_DOUBLE_ROUND;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH: r_image_width <= i_cfg_data;
                REG_ROUND_MODE:  r_round_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // row length clamped to [1, MAX_WIDTH], pairs end on an even count
    always_comb begin
        w_width_ext = CMP_W'(r_image_width);
        if (w_width_ext == '0) begin
            w_len = LEN_W'(1);
        end else if (w_width_ext > CMP_W'(MAX_WIDTH)) begin
            w_len = LEN_W'(MAX_WIDTH);
        end else begin
            w_len = w_width_ext[LEN_W-1:0];
        end
        w_paired = {w_len[LEN_W-1:1], 1'b0};
    end

    // start of frame forces column 0 of an even row
    assign w_col      = i_start_of_frame ? '0 : r_col;
    assign w_row_odd  = i_start_of_frame ? 1'b0 : r_row_odd;
    assign w_col_ext  = LEN_W'(w_col);
    assign w_col_next = w_col_ext + LEN_W'(1);
    assign w_row_end  = (w_col_next >= w_len);

    // lower-right pixel of a complete block
    assign w_block = w_row_odd && w_col[0] && (w_col_ext < w_paired);

    // handshake and pipeline advance
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_adv   = !r_s1_valid || w_out_free;
    assign o_in_stall = !w_s1_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    // item taken inside a row, same frame
    assign w_mid_row  = w_accept && !i_start_of_frame && !w_row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row_odd <= 1'b0;
            r_held    <= '0;
        end else if (w_accept) begin
            r_col     <= w_row_end ? '0 : w_col_next[COL_W-1:0];
            r_row_odd <= w_row_end ? !w_row_odd : w_row_odd;
            // left pixel of the lower row
            if (w_row_odd && !w_col[0]) begin
                r_held <= i_pixel;
            end
        end
    end

    // even rows write, every taken item reads its column back
    bds_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && !w_row_odd),
        .i_rd_en   (w_accept),
        .i_addr    (w_col),
        .i_wdata   (i_pixel),
        .o_rd_data (w_rd_data)
    );

    // previous read is the upper-left pixel when the block closes
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tl <= w_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_s1_valid <= w_accept && w_block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_block) begin
            r_s1_br   <= i_pixel;
            r_s1_last <= (w_col_next == w_paired);
        end
    end

    // output register, ram data now holds the upper-right pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_out_pixel <= block_value(r_tl, w_rd_data, r_held, r_s1_br, r_round_mode);
            r_out_last  <= r_s1_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_pixel   = r_out_pixel;
    assign o_last_in_row = r_out_last;

    // a waiting block is never dropped while the output is blocked
    `BDS_ASSERT(a_s1_kept, (r_s1_valid && !w_out_free) |=> r_s1_valid, "block lost in stall")
    // input stalls only behind a pending block
    `BDS_ASSERT(a_stall_cause, o_in_stall |-> (r_s1_valid && r_out_valid), "spurious stall")
    // row parity holds inside a row
    `BDS_ASSERT(a_row_hold, w_mid_row |=> $stable(r_row_odd), "row parity flipped mid-row")
    // nothing leaves right after reset
    `BDS_ASSERT_RST(a_rst_quiet, !i_rst_n |=> !r_out_valid, "output valid after reset")

endmodule

`default_nettype wire
